// ----- src/siu_pkg.sv -----
// ----------------------------------------------------------------------------
// siu_pkg
// Shared types and codes for the string instruction unit.
// ----------------------------------------------------------------------------
package siu_pkg;

	localparam logic [2:0] OP_MOVS = 3'd0;
	localparam logic [2:0] OP_CMPS = 3'd1;
	localparam logic [2:0] OP_SCAS = 3'd2;
	localparam logic [2:0] OP_LODS = 3'd3;
	localparam logic [2:0] OP_STOS = 3'd4;

	localparam logic [1:0] RP_NONE = 2'd0;
	localparam logic [1:0] RP_Z    = 2'd1;
	localparam logic [1:0] RP_NZ   = 2'd2;
	localparam logic [1:0] RP_BAD  = 2'd3;

	localparam logic REQ_SETUP   = 1'b0;
	localparam logic REQ_ELEMENT = 1'b1;

	localparam logic REG_DATA_SEG  = 1'b0;
	localparam logic REG_EXTRA_SEG = 1'b1;

	// flag bit positions
	localparam int FL_CF = 0;
	localparam int FL_PF = 1;
	localparam int FL_AF = 2;
	localparam int FL_ZF = 3;
	localparam int FL_SF = 4;
	localparam int FL_OF = 5;

	typedef struct packed {
		logic        req_type;
		logic [2:0]  string_op;
		logic        word_size;
		logic [1:0]  repeat_mode;
		logic [15:0] count_in;
		logic [15:0] src_offset_in;
		logic [15:0] dst_offset_in;
		logic [15:0] acc_in;
		logic        direction;
		logic [15:0] src_data;
		logic [15:0] dst_data;
	} item_t;

	typedef struct packed {
		logic [2:0]  op_kind;
		logic        is_word;
		logic [1:0]  rep_kind;
		logic [15:0] counter;
		logic [15:0] source_offset;
		logic [15:0] dest_offset;
		logic [15:0] accumulator;
		logic        step_down;
		logic [5:0]  arith_flags;
		logic        busy;
	} state_t;

	typedef struct packed {
		logic [19:0] src_address;
		logic [19:0] dst_address;
		logic        write_enable;
		logic [19:0] write_address;
		logic [15:0] write_data;
		logic [15:0] count_out;
		logic [15:0] src_offset_out;
		logic [15:0] dst_offset_out;
		logic [15:0] acc_out;
		logic [5:0]  status_flags;
		logic        last;
	} result_t;

	typedef struct packed {
		logic [15:0] data_segment;
		logic [15:0] extra_segment;
	} seg_t;

	function automatic logic [19:0] phys(input logic [15:0] seg, input logic [15:0] off);
		phys = {seg, 4'b0000} + {4'b0000, off};
	endfunction

endpackage

// ----- src/siu_flags.sv -----
// ----------------------------------------------------------------------------
// siu_flags
// Subtract flags (CF PF AF ZF SF OF) for a byte or word compare.
// ----------------------------------------------------------------------------
module siu_flags import siu_pkg::*; (
	input  logic [15:0] a,
	input  logic [15:0] b,
	input  logic        word,
	output logic [5:0]  flags
);

	logic [15:0] mask;
	logic [15:0] am, bm, r, ov;
	logic        msb_r, msb_ov;

	always_comb begin
		mask   = word ? 16'hFFFF : 16'h00FF;
		am     = a & mask;
		bm     = b & mask;
		r      = (am - bm) & mask;
		ov     = (am ^ bm) & (am ^ r);
		msb_r  = word ? r[15] : r[7];
		msb_ov = word ? ov[15] : ov[7];
		flags        = '0;
		flags[FL_CF] = am < bm;
		flags[FL_PF] = ~^r[7:0];
		flags[FL_AF] = am[4] ^ bm[4] ^ r[4];
		flags[FL_ZF] = r == 16'h0000;
		flags[FL_SF] = msb_r;
		flags[FL_OF] = msb_ov;
	end

endmodule

// ----- src/siu_cfg.sv -----
// ----------------------------------------------------------------------------
// siu_cfg
// APB register file holding the two segment registers.
// ----------------------------------------------------------------------------
module siu_cfg import siu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output seg_t        segs
);

	logic [15:0] data_seg_q;
	logic [15:0] extra_seg_q;
	logic        wr;

	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_seg_q  <= '0;
			extra_seg_q <= '0;
		end else if (wr) begin
			case (paddr[2])
				REG_DATA_SEG:  data_seg_q  <= pwdata[15:0];
				REG_EXTRA_SEG: extra_seg_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_DATA_SEG:  prdata = {16'h0000, data_seg_q};
			REG_EXTRA_SEG: prdata = {16'h0000, extra_seg_q};
			default:       prdata = '0;
		endcase
	end

	assign segs.data_segment  = data_seg_q;
	assign segs.extra_segment = extra_seg_q;

endmodule

// ----- src/siu_exec.sv -----
// ----------------------------------------------------------------------------
// siu_exec
// One setup or element step: next architectural state and the result item.
// ----------------------------------------------------------------------------
module siu_exec import siu_pkg::*; (
	input  item_t   item,
	input  state_t  cur,
	input  seg_t    segs,
	output state_t  nxt,
	output result_t res
);

	logic [15:0] mask, step, src, dst, cmp_a;
	logic [5:0]  cmp_flags;
	logic [1:0]  rep;
	logic        done, we, is_cmp, zf;
	logic [19:0] wa;
	logic [15:0] wd;
	logic [15:0] cnt_dec;

	assign mask  = cur.is_word ? 16'hFFFF : 16'h00FF;
	assign src   = item.src_data & mask;
	assign dst   = item.dst_data & mask;
	assign cmp_a = (cur.op_kind == OP_SCAS) ? (cur.accumulator & mask) : src;

	siu_flags u_flags (
		.a     (cmp_a),
		.b     (dst),
		.word  (cur.is_word),
		.flags (cmp_flags)
	);

	always_comb begin
		nxt     = cur;
		we      = 1'b0;
		wa      = '0;
		wd      = '0;
		done    = 1'b1;
		is_cmp  = 1'b0;
		rep     = item.repeat_mode;
		step    = cur.is_word ? 16'd2 : 16'd1;
		cnt_dec = cur.counter - 16'd1;
		zf      = cmp_flags[FL_ZF];

		if (item.req_type == REQ_SETUP) begin
			if (rep == RP_BAD)
				rep = RP_NONE;
			if (rep != RP_NONE && item.string_op != OP_CMPS && item.string_op != OP_SCAS)
				rep = RP_Z;
			nxt.op_kind       = item.string_op;
			nxt.is_word       = item.word_size;
			nxt.rep_kind      = rep;
			nxt.counter       = item.count_in;
			nxt.source_offset = item.src_offset_in;
			nxt.dest_offset   = item.dst_offset_in;
			nxt.accumulator   = item.acc_in;
			nxt.step_down     = item.direction;
			nxt.busy          = !(item.string_op > OP_STOS ||
				(rep != RP_NONE && item.count_in == 16'h0000));
			done              = !nxt.busy;
		end else if (cur.busy) begin
			case (cur.op_kind)
				OP_MOVS: begin
					we = 1'b1;
					wa = phys(segs.extra_segment, cur.dest_offset);
					wd = src;
				end
				OP_CMPS, OP_SCAS: begin
					nxt.arith_flags = cmp_flags;
					is_cmp          = 1'b1;
				end
				OP_LODS: nxt.accumulator = (cur.accumulator & ~mask) | src;
				default: begin
					we = 1'b1;
					wa = phys(segs.extra_segment, cur.dest_offset);
					wd = cur.accumulator & mask;
				end
			endcase

			if (cur.op_kind == OP_MOVS || cur.op_kind == OP_CMPS || cur.op_kind == OP_LODS)
				nxt.source_offset = cur.step_down ? cur.source_offset - step
				                                  : cur.source_offset + step;
			if (cur.op_kind != OP_LODS)
				nxt.dest_offset = cur.step_down ? cur.dest_offset - step
				                                : cur.dest_offset + step;

			if (cur.rep_kind != RP_NONE) begin
				nxt.counter = cnt_dec;
				done        = cnt_dec == 16'h0000;
				if (is_cmp && cur.rep_kind == RP_Z && !zf)
					done = 1'b1;
				if (is_cmp && cur.rep_kind == RP_NZ && zf)
					done = 1'b1;
			end
			nxt.busy = !done;
		end

		res.src_address    = phys(segs.data_segment, nxt.source_offset);
		res.dst_address    = phys(segs.extra_segment, nxt.dest_offset);
		res.write_enable   = we;
		res.write_address  = wa;
		res.write_data     = wd;
		res.count_out      = nxt.counter;
		res.src_offset_out = nxt.source_offset;
		res.dst_offset_out = nxt.dest_offset;
		res.acc_out        = nxt.accumulator;
		res.status_flags   = nxt.arith_flags;
		res.last           = done;
	end

endmodule

// ----- src/string_instruction_unit.sv -----
// ----------------------------------------------------------------------------
// string_instruction_unit
// String move, compare, scan, load and store unit with repeat handling.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+------------------------------
//  input    | in        | in_valid / in_stall | req_type .. dst_data
//  result   | out       | out_valid/out_stall | src_address .. last
//  config   | in        | APB psel/penable    | paddr, pwdata, prdata
//
//  One transfer per cycle sustained while out_stall is low; each item yields
//  one result, held first in the input register, then in the result register.
//  The CX/SI/DI/AX/flags state sits in one register bank updated as an item
//  moves from the input register to the result register.
//  Reset clears the state bank and both valid bits; payload regs are not reset.
//  out_stall holds the result register; in_stall is raised only while the
//  input register is full and its item cannot move on.
//
module string_instruction_unit import siu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        req_type,
	input  logic [2:0]  string_op,
	input  logic        word_size,
	input  logic [1:0]  repeat_mode,
	input  logic [15:0] count_in,
	input  logic [15:0] src_offset_in,
	input  logic [15:0] dst_offset_in,
	input  logic [15:0] acc_in,
	input  logic        direction,
	input  logic [15:0] src_data,
	input  logic [15:0] dst_data,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [19:0] src_address,
	output logic [19:0] dst_address,
	output logic        write_enable,
	output logic [19:0] write_address,
	output logic [15:0] write_data,
	output logic [15:0] count_out,
	output logic [15:0] src_offset_out,
	output logic [15:0] dst_offset_out,
	output logic [15:0] acc_out,
	output logic [5:0]  status_flags,
	output logic        last,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	item_t   item_in;
	item_t   item_s1;
	logic    valid_s1;
	state_t  state_q;
	state_t  state_nxt;
	result_t res_nxt;
	result_t res_q;
	logic    out_valid_q;
	logic    out_free;
	logic    adv;
	logic    take;
	seg_t    segs;

	// segment registers
	siu_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.segs    (segs)
	);

	assign item_in = '{req_type: req_type, string_op: string_op, word_size: word_size,
		repeat_mode: repeat_mode, count_in: count_in, src_offset_in: src_offset_in,
		dst_offset_in: dst_offset_in, acc_in: acc_in, direction: direction,
		src_data: src_data, dst_data: dst_data};

	// result register can take a new item when empty or being drained
	assign out_free = !out_valid_q || !out_stall;
	assign adv      = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign take     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (take || adv)
			valid_s1 <= take;
	end

	always_ff @(posedge clk) begin
		if (take)
			item_s1 <= item_in;
	end

	// the step itself: reads the state bank, writes back on advance
	siu_exec u_exec (
		.item (item_s1),
		.cur  (state_q),
		.segs (segs),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv)
				state_q <= state_nxt;
			if (out_free)
				out_valid_q <= adv;
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			res_q <= res_nxt;
	end

	assign out_valid      = out_valid_q;
	assign src_address    = res_q.src_address;
	assign dst_address    = res_q.dst_address;
	assign write_enable   = res_q.write_enable;
	assign write_address  = res_q.write_address;
	assign write_data     = res_q.write_data;
	assign count_out      = res_q.count_out;
	assign src_offset_out = res_q.src_offset_out;
	assign dst_offset_out = res_q.dst_offset_out;
	assign acc_out        = res_q.acc_out;
	assign status_flags   = res_q.status_flags;
	assign last           = res_q.last;

`ifndef ASSERT_OFF
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with empty input register");

	a_adv_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid)
		else $error("advanced item did not reach the result register");

	a_last_clears_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && res_nxt.last) |=> !state_q.busy)
		else $error("finished instruction left the unit busy");

	a_nowrite_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !write_enable) |-> (write_address == 20'h0 && write_data == 16'h0))
		else $error("write fields set on a result without a write");
`endif

endmodule
